// ----- design/sha1de_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1de_pkg
// Types, round constants and helper functions of the SHA-1 digest engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1de_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } sha1de_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } sha1de_out_t;

    localparam logic [31:0] K_STAGE0 = 32'h5a827999;
    localparam logic [31:0] K_STAGE1 = 32'h6ed9eba1;
    localparam logic [31:0] K_STAGE2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_STAGE3 = 32'hca62c1d6;

    localparam logic [31:0] IV_WORD0 = 32'h67452301;
    localparam logic [31:0] IV_WORD1 = 32'hefcdab89;
    localparam logic [31:0] IV_WORD2 = 32'h98badcfe;
    localparam logic [31:0] IV_WORD3 = 32'h10325476;
    localparam logic [31:0] IV_WORD4 = 32'hc3d2e1f0;

    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;
    localparam int          ROUNDS = 80;
    localparam int          CHAIN_WORDS = 5;
    localparam int          BLOCK_WORDS = 16;

    function automatic logic [31:0] chain_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = IV_WORD0;
            3'd1: v = IV_WORD1;
            3'd2: v = IV_WORD2;
            3'd3: v = IV_WORD3;
            3'd4: v = IV_WORD4;
            default: v = IV_WORD0;
        endcase
        return v;
    endfunction

    // counts below four keep the top bytes and put the pad byte right after them
    function automatic logic [31:0] pad_word(input logic [31:0] data, input logic [2:0] cnt);
        logic [31:0] v;
        case (cnt)
            3'd0: v = {PAD_BYTE, 24'h0};
            3'd1: v = {data[31:24], PAD_BYTE, 16'h0};
            3'd2: v = {data[31:16], PAD_BYTE, 8'h0};
            3'd3: v = {data[31:8], PAD_BYTE};
            default: v = data;
        endcase
        return v;
    endfunction

endpackage

// ----- design/sha1de_ram.sv -----
// ----------------------------------------------------------------------------
// sha1de_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1de_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/sha1de_round.sv -----
// ----------------------------------------------------------------------------
// sha1de_round
// One SHA-1 round: stage function, stage constant and the new working word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1de_round (
    input  logic [6:0]  rnd,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] e,
    input  logic [31:0] w,
    output logic [31:0] t
);

    logic [31:0] f;
    logic [31:0] k;

    always_comb begin
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
            k = sha1de_pkg::K_STAGE0;
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
            k = sha1de_pkg::K_STAGE1;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1de_pkg::K_STAGE2;
        end else begin
            f = b ^ c ^ d;
            k = sha1de_pkg::K_STAGE3;
        end
    end

    assign t = {a[26:0], a[31:27]} + f + e + k + w;

endmodule

// ----- design/sha1_digest_engine.sv -----
// ----------------------------------------------------------------------------
// sha1_digest_engine
// SHA-1 hash of a word stream with padding, length append and digest output.
// ----------------------------------------------------------------------------
// Message words are taken one per cycle into a 16-word block RAM until the
// block is full. A full block is compressed by a single round unit, one round
// per cycle: the chaining words are loaded from the chain RAM, 80 rounds are
// run, and the chaining words are read, added and written back. The last word
// of a request is followed by padding of the remaining block words, one or two
// compressions, and then the five digest words, each shown after a chain RAM
// read and held until taken. Input is not accepted while a block is compressed,
// the message is padded or the digest is being delivered.
`timescale 1ns / 1ps

module sha1_digest_engine (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  sha1de_pkg::sha1de_in_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output sha1de_pkg::sha1de_out_t m_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_LOADC = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_ADDC  = 3'd4;
    localparam logic [2:0] ST_OUTRD = 3'd5;
    localparam logic [2:0] ST_OUTLD = 3'd6;
    localparam logic [2:0] ST_OUTW  = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [3:0]  fill_idx_reg, fill_idx_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic        padding_reg, padding_next;
    logic        pad_pend_reg, pad_pend_next;
    logic        len_fits_reg, len_fits_next;
    logic [4:0]  chain_vld_reg, chain_vld_next;
    logic        chain_rd_vld_reg;
    logic [2:0]  chain_rd_idx_reg;
    logic        m_valid_reg, m_valid_next;

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    sha1de_pkg::sha1de_out_t m_data_reg, m_data_next;

    logic        blk_we;
    logic [3:0]  blk_waddr;
    logic [31:0] blk_wdata;
    logic [3:0]  blk_raddr;
    logic [31:0] blk_rdata;

    logic        chain_we;
    logic [2:0]  chain_waddr;
    logic [31:0] chain_wdata;
    logic [2:0]  chain_raddr;
    logic [31:0] chain_ram_q;
    logic [31:0] chain_q;

    logic        s_fire;
    logic [2:0]  count_eff;
    logic [31:0] w_cur;
    logic [31:0] w_mix;
    logic [31:0] round_t;

    sha1de_ram #(
        .WIDTH(32),
        .DEPTH(sha1de_pkg::BLOCK_WORDS)
    ) u_block_ram (
        .aclk    (aclk),
        .wr_en   (blk_we),
        .wr_addr (blk_waddr),
        .wr_data (blk_wdata),
        .rd_addr (blk_raddr),
        .rd_data (blk_rdata)
    );

    sha1de_ram #(
        .WIDTH(32),
        .DEPTH(sha1de_pkg::CHAIN_WORDS)
    ) u_chain_ram (
        .aclk    (aclk),
        .wr_en   (chain_we),
        .wr_addr (chain_waddr),
        .wr_data (chain_wdata),
        .rd_addr (chain_raddr),
        .rd_data (chain_ram_q)
    );

    sha1de_round u_round (
        .rnd (cnt_reg),
        .a   (a_reg),
        .b   (b_reg),
        .c   (c_reg),
        .d   (d_reg),
        .e   (e_reg),
        .w   (w_cur),
        .t   (round_t)
    );

    // entries never written since the last digest read as the initial values
    assign chain_q = chain_rd_vld_reg ? chain_ram_q : sha1de_pkg::chain_iv(chain_rd_idx_reg);

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign count_eff = (!s_data.last_word || s_data.byte_count > sha1de_pkg::FULL_WORD_BYTES) ?
                       sha1de_pkg::FULL_WORD_BYTES : s_data.byte_count;

    assign w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_cur = (cnt_reg < 7'd16) ? blk_rdata : {w_mix[30:0], w_mix[31]};

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fill_idx_next  = fill_idx_reg;
        bit_len_next   = bit_len_reg;
        padding_next   = padding_reg;
        pad_pend_next  = pad_pend_reg;
        len_fits_next  = len_fits_reg;
        chain_vld_next = chain_vld_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        win_next = win_reg;

        blk_we      = 1'b0;
        blk_waddr   = fill_idx_reg;
        blk_wdata   = s_data.data_word;
        blk_raddr   = 4'd0;
        chain_we    = 1'b0;
        chain_waddr = 3'd0;
        chain_wdata = chain_q + a_reg;
        chain_raddr = (cnt_reg < 7'd5) ? cnt_reg[2:0] : 3'd0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    blk_we        = 1'b1;
                    blk_wdata     = s_data.last_word ?
                                    sha1de_pkg::pad_word(s_data.data_word, count_eff) :
                                    s_data.data_word;
                    bit_len_next  = bit_len_reg + {58'd0, count_eff, 3'd0};
                    fill_idx_next = fill_idx_reg + 4'd1;
                    if (s_data.last_word) begin
                        padding_next  = 1'b1;
                        pad_pend_next = (count_eff == sha1de_pkg::FULL_WORD_BYTES);
                        len_fits_next = (count_eff != sha1de_pkg::FULL_WORD_BYTES) &&
                                        (fill_idx_reg <= 4'd13);
                    end
                    if (fill_idx_reg == 4'd15) begin
                        state_next = ST_LOADC;
                        cnt_next   = 7'd0;
                    end else if (s_data.last_word) begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                blk_we = 1'b1;
                if (pad_pend_reg) begin
                    blk_wdata     = {sha1de_pkg::PAD_BYTE, 24'h0};
                    pad_pend_next = 1'b0;
                    len_fits_next = (fill_idx_reg <= 4'd13);
                end else if (len_fits_reg && fill_idx_reg == 4'd14) begin
                    blk_wdata = bit_len_reg[63:32];
                end else if (len_fits_reg && fill_idx_reg == 4'd15) begin
                    blk_wdata = bit_len_reg[31:0];
                end else begin
                    blk_wdata = 32'd0;
                end
                fill_idx_next = fill_idx_reg + 4'd1;
                if (fill_idx_reg == 4'd15) begin
                    state_next = ST_LOADC;
                    cnt_next   = 7'd0;
                end
            end
            ST_LOADC: begin
                if (cnt_reg != 7'd0) begin
                    a_next = b_reg;
                    b_next = c_reg;
                    c_next = d_reg;
                    d_next = e_reg;
                    e_next = chain_q;
                end
                if (cnt_reg == 7'd5) begin
                    state_next = ST_ROUND;
                    cnt_next   = 7'd0;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ROUND: begin
                blk_raddr = cnt_reg[3:0] + 4'd1;
                a_next = round_t;
                b_next = a_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                d_next = c_reg;
                e_next = d_reg;
                for (int i = 0; i < 15; i++) begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = w_cur;
                if (cnt_reg == 7'(sha1de_pkg::ROUNDS - 1)) begin
                    state_next = ST_ADDC;
                    cnt_next   = 7'd0;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ADDC: begin
                if (cnt_reg != 7'd0) begin
                    chain_we    = 1'b1;
                    chain_waddr = cnt_reg[2:0] - 3'd1;
                    chain_vld_next[chain_waddr] = 1'b1;
                    a_next = b_reg;
                    b_next = c_reg;
                    c_next = d_reg;
                    d_next = e_reg;
                    e_next = chain_wdata;
                end
                if (cnt_reg == 7'd5) begin
                    cnt_next = 7'd0;
                    if (!padding_reg) begin
                        state_next = ST_IDLE;
                    end else if (len_fits_reg && !pad_pend_reg) begin
                        state_next = ST_OUTRD;
                    end else begin
                        state_next    = ST_FILL;
                        len_fits_next = 1'b1;
                    end
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_OUTRD: begin
                state_next = ST_OUTLD;
            end
            ST_OUTLD: begin
                m_valid_next            = 1'b1;
                m_data_next.digest_word = chain_q;
                m_data_next.word_index  = cnt_reg[2:0];
                m_data_next.digest_last = (cnt_reg == 7'd4);
                state_next              = ST_OUTW;
            end
            ST_OUTW: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (cnt_reg == 7'd4) begin
                        // digest done: back to the initial chaining state
                        state_next     = ST_IDLE;
                        cnt_next       = 7'd0;
                        chain_vld_next = 5'd0;
                        bit_len_next   = 64'd0;
                        fill_idx_next  = 4'd0;
                        padding_next   = 1'b0;
                        pad_pend_next  = 1'b0;
                        len_fits_next  = 1'b0;
                    end else begin
                        state_next = ST_OUTRD;
                        cnt_next   = cnt_reg + 7'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= 7'd0;
            fill_idx_reg     <= 4'd0;
            bit_len_reg      <= 64'd0;
            padding_reg      <= 1'b0;
            pad_pend_reg     <= 1'b0;
            len_fits_reg     <= 1'b0;
            chain_vld_reg    <= 5'd0;
            chain_rd_vld_reg <= 1'b0;
            chain_rd_idx_reg <= 3'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            fill_idx_reg     <= fill_idx_next;
            bit_len_reg      <= bit_len_next;
            padding_reg      <= padding_next;
            pad_pend_reg     <= pad_pend_next;
            len_fits_reg     <= len_fits_next;
            chain_vld_reg    <= chain_vld_next;
            chain_rd_vld_reg <= chain_vld_reg[chain_raddr];
            chain_rd_idx_reg <= chain_raddr;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        win_reg    <= win_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sha1_digest_engine. Messages of directed and random
// length and content, including empty, short-count and two-pad-block cases,
// are streamed in with random gaps. A bit-accurate SHA-1 predictor computes
// the five digest words of every message, and each digest word taken from the
// engine is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int ITEM_TARGET  = 360;
    localparam int HOLD_AT      = 52;
    localparam int HOLD_CYCLES  = 500;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 300;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        sha1de_pkg::sha1de_in_t req;
        int                     gap;
        bit                     drain;
    } word_slot_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    sha1de_pkg::sha1de_in_t  s_data = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    sha1de_pkg::sha1de_out_t m_data;

    word_slot_t              word_backlog [$];
    sha1de_pkg::sha1de_out_t expected_digest_words [$];

    // predictor state
    logic [31:0] hash_state [sha1de_pkg::CHAIN_WORDS];
    logic [31:0] block_words [sha1de_pkg::BLOCK_WORDS];
    logic [5:0]  fill_bytes;
    logic [63:0] bit_total;

    logic        req_fire = 1'b0;
    logic        rsp_fire = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          rsp_count = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;
    int          tx_calm = 0;
    int          rx_calm = 0;
    int          rx_draw;
    bit          drain_next = 1'b0;
    sha1de_pkg::sha1de_out_t want;

    sha1_digest_engine uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // idle cycles for one item, with stretches of back-to-back traffic
    function automatic int draw_gap(inout int calm);
        if (calm != 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [31:0] random_data();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return 32'h0000_0000;
        if (sel == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    task automatic restart_message();
        hash_state[0] = sha1de_pkg::IV_WORD0;
        hash_state[1] = sha1de_pkg::IV_WORD1;
        hash_state[2] = sha1de_pkg::IV_WORD2;
        hash_state[3] = sha1de_pkg::IV_WORD3;
        hash_state[4] = sha1de_pkg::IV_WORD4;
        fill_bytes = '0;
        bit_total = '0;
    endtask

    // place one byte, compress when the block is full
    task automatic push_byte(input logic [7:0] octet);
        logic [31:0] w [sha1de_pkg::ROUNDS];
        logic [31:0] a, b, c, d, e, f, k, t;
        block_words[fill_bytes[5:2]][8 * (3 - fill_bytes[1:0]) +: 8] = octet;
        fill_bytes = fill_bytes + 6'd1;
        if (fill_bytes == 6'd0) begin
            for (int r = 0; r < sha1de_pkg::BLOCK_WORDS; r++)
                w[r] = block_words[r];
            for (int r = sha1de_pkg::BLOCK_WORDS; r < sha1de_pkg::ROUNDS; r++)
                w[r] = rotl(w[r - 3] ^ w[r - 8] ^ w[r - 14] ^ w[r - 16], 1);
            a = hash_state[0];
            b = hash_state[1];
            c = hash_state[2];
            d = hash_state[3];
            e = hash_state[4];
            for (int r = 0; r < sha1de_pkg::ROUNDS; r++) begin
                if (r < 20) begin
                    f = (b & c) | (~b & d);
                    k = sha1de_pkg::K_STAGE0;
                end else if (r < 40) begin
                    f = b ^ c ^ d;
                    k = sha1de_pkg::K_STAGE1;
                end else if (r < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = sha1de_pkg::K_STAGE2;
                end else begin
                    f = b ^ c ^ d;
                    k = sha1de_pkg::K_STAGE3;
                end
                t = rotl(a, 5) + f + e + k + w[r];
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = t;
            end
            hash_state[0] = hash_state[0] + a;
            hash_state[1] = hash_state[1] + b;
            hash_state[2] = hash_state[2] + c;
            hash_state[3] = hash_state[3] + d;
            hash_state[4] = hash_state[4] + e;
        end
    endtask

    task automatic predict_request(input sha1de_pkg::sha1de_in_t req);
        int n;
        sha1de_pkg::sha1de_out_t res;
        n = (req.last_word && req.byte_count < sha1de_pkg::FULL_WORD_BYTES) ?
            int'(req.byte_count) : int'(sha1de_pkg::FULL_WORD_BYTES);
        for (int i = 0; i < n; i++)
            push_byte(req.data_word[31 - 8 * i -: 8]);
        bit_total = bit_total + 64'(n * 8);
        if (req.last_word) begin
            push_byte(sha1de_pkg::PAD_BYTE);
            while (fill_bytes != 6'd56)
                push_byte(8'h00);
            for (int i = 0; i < 8; i++)
                push_byte(bit_total[63 - 8 * i -: 8]);
            for (int i = 0; i < sha1de_pkg::CHAIN_WORDS; i++) begin
                res.digest_word = hash_state[i];
                res.word_index  = 3'(i);
                res.digest_last = (i == sha1de_pkg::CHAIN_WORDS - 1);
                expected_digest_words.push_back(res);
            end
            restart_message();
        end
    endtask

    task automatic flag_error(input string msg);
        mismatches = mismatches + 1;
        if (mismatches <= REPORT_MAX)
            $display("%s", msg);
    endtask

    task automatic queue_word(input logic [31:0] data, input logic [2:0] cnt, input bit last);
        word_slot_t slot;
        slot.req.data_word  = data;
        slot.req.byte_count = cnt;
        slot.req.last_word  = last;
        slot.gap   = draw_gap(tx_calm);
        slot.drain = drain_next;
        drain_next = 1'b0;
        word_backlog.push_back(slot);
    endtask

    task automatic queue_random_message(input int n_words);
        for (int i = 0; i < n_words - 1; i++)
            queue_word(random_data(),
                       ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) :
                                                     sha1de_pkg::FULL_WORD_BYTES,
                       1'b0);
        queue_word(random_data(), 3'($urandom_range(0, 7)), 1'b1);
    endtask

    // request side driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_fire) begin
            if (gap_left != 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (word_backlog.size() != 0 &&
                         !(word_backlog[0].drain && expected_digest_words.size() != 0)) begin
                s_data   <= word_backlog[0].req;
                gap_left <= word_backlog[0].gap;
                s_valid  <= 1'b1;
                word_backlog.delete(0);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // digest side ready
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && rsp_count == HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (rsp_fire) begin
            rx_draw = draw_gap(rx_calm);
            if (rx_draw == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready    <= 1'b0;
                stall_left <= rx_draw - 1;
            end
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        req_fire <= aresetn && s_valid && s_ready;
        rsp_fire <= aresetn && m_valid && m_ready;
        if (aresetn && m_valid && m_ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_digest_words.size() == 0) begin
                flag_error($sformatf("unexpected digest word %h index %0d last %0b",
                                     m_data.digest_word, m_data.word_index,
                                     m_data.digest_last));
            end else begin
                want = expected_digest_words.pop_front();
                if (m_data.digest_word !== want.digest_word ||
                    m_data.word_index !== want.word_index ||
                    m_data.digest_last !== want.digest_last)
                    flag_error($sformatf({"digest word %0d: expected %h index %0d last %0b,",
                                          " got %h index %0d last %0b"},
                                         rsp_count, want.digest_word, want.word_index,
                                         want.digest_last, m_data.digest_word,
                                         m_data.word_index, m_data.digest_last));
            end
        end
        if (aresetn && s_valid && s_ready)
            predict_request(s_data);
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("sha1_digest_engine verification failed");
            $finish;
        end
    end

    initial begin
        int msg_idx;
        int len_sel;
        aresetn = 1'b0;
        restart_message();

        // empty message
        queue_word(32'h0000_0000, 3'd0, 1'b1);
        // short last word with ignored low byte
        queue_word(32'h6162_63ff, 3'd3, 1'b1);
        queue_word(32'hffff_ffff, 3'd1, 1'b1);
        queue_word(32'h1234_5678, 3'd2, 1'b1);
        queue_word(32'hffff_ffff, sha1de_pkg::FULL_WORD_BYTES, 1'b1);
        // count above four saturates
        queue_word(32'hdead_beef, 3'd7, 1'b1);
        // short counts before the last word count as full words
        queue_word(32'hcafe_f00d, 3'd1, 1'b0);
        queue_word(32'h0bad_c0de, 3'd6, 1'b0);
        queue_word(32'h89ab_cdef, 3'd2, 1'b1);
        // 56 bytes, length spills into a second pad block
        for (int i = 0; i < 13; i++)
            queue_word(32'h0101_0101 * 32'(i + 1), sha1de_pkg::FULL_WORD_BYTES, 1'b0);
        queue_word(32'hffff_ffff, sha1de_pkg::FULL_WORD_BYTES, 1'b1);

        msg_idx = 0;
        while (word_backlog.size() < ITEM_TARGET) begin
            drain_next = (msg_idx % 7 == 5);
            len_sel = $urandom_range(0, 9);
            if (len_sel < 6)
                queue_random_message($urandom_range(1, 13));
            else if (len_sel < 9)
                queue_random_message($urandom_range(13, 17));
            else
                queue_random_message($urandom_range(30, 48));
            msg_idx = msg_idx + 1;
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (word_backlog.size() != 0 || s_valid || expected_digest_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("sha1_digest_engine verification clean");
        else
            $display("sha1_digest_engine verification failed");
        $finish;
    end

endmodule
